[rtl/core/eased_value_interpolator_defines.svh]
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef EASED_VALUE_INTERPOLATOR_DEFINES_SVH
`define EASED_VALUE_INTERPOLATOR_DEFINES_SVH

// Antecedent in one cycle, consequent in the next.
`define EVI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evi: next-cycle check failed");

// Antecedent and consequent in the same cycle.
`define EVI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evi: same-cycle check failed");

`endif

[rtl/core/evi_pkg.sv]
package evi_pkg;

    // Fixed field widths
    localparam int VALUE_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_EASING_MODE   = 2'd0,
        CFG_INITIAL_VALUE = 2'd1,
        CFG_FINAL_VALUE   = 2'd2,
        CFG_DURATION      = 2'd3
    } cfg_index_t;

    // Easing curves
    typedef enum logic [1:0] {
        MODE_LINEAR   = 2'd0,
        MODE_CUBIC_IN = 2'd1,
        MODE_CUBIC_OUT = 2'd2,
        MODE_CUBIC_IN_OUT = 2'd3
    } ease_mode_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_FINAL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_XSEL,
        OP_SQ,
        OP_CU,
        OP_EASE,
        OP_SCALE,
        OP_SUM,
        OP_PUSH
    } dp_op_t;

    // Input and output words
    typedef struct packed {
        logic                  command;
        logic [TIME_BITS-1:0]  time_now;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] current_value;
        logic                         done_res;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic   take;
        dp_op_t op;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic finished;
        logic end_reached;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/evi_ctrl.sv]
module evi_ctrl
    import evi_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int CW = $clog2(FRAC_BITS);
    localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_DINIT,
        S_DIV,
        S_XSEL,
        S_SQ,
        S_CU,
        S_EASE,
        S_SCALE,
        S_SUM,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    dp_op_t          op_reg, op_next;
    logic            stall_reg, stall_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            accept;

    assign accept   = in_valid && !stall_reg;
    assign in_stall = stall_reg;
    assign cmd.take = accept;
    assign cmd.op   = op_reg;

    // Next state and the datapath operation for the coming cycle
    always_comb
    begin
        state_next = state_reg;
        op_next    = OP_NONE;
        stall_next = stall_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                    stall_next = 1'b1;
                end
            end
            S_EVAL:
            begin
                priority if (status.is_start)
                begin
                    state_next = S_APPLY;
                    op_next    = OP_START;
                end
                else if (status.finished)
                begin
                    state_next = S_OUT;
                    op_next    = OP_PUSH;
                end
                else if (status.end_reached)
                begin
                    state_next = S_APPLY;
                    op_next    = OP_FINAL;
                end
                else
                begin
                    state_next = S_DINIT;
                    op_next    = OP_DIV_INIT;
                    cnt_next   = CNT_LAST;
                end
            end
            S_APPLY:
            begin
                state_next = S_OUT;
                op_next    = OP_PUSH;
            end
            S_DINIT:
            begin
                state_next = S_DIV;
                op_next    = OP_DIV_STEP;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_XSEL;
                    op_next    = OP_XSEL;
                end
                else
                begin
                    op_next  = OP_DIV_STEP;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_XSEL:
            begin
                state_next = S_SQ;
                op_next    = OP_SQ;
            end
            S_SQ:
            begin
                state_next = S_CU;
                op_next    = OP_CU;
            end
            S_CU:
            begin
                state_next = S_EASE;
                op_next    = OP_EASE;
            end
            S_EASE:
            begin
                state_next = S_SCALE;
                op_next    = OP_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_SUM;
                op_next    = OP_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
                op_next    = OP_PUSH;
            end
            S_OUT:
            begin
                // datapath loads the output register in the same cycle
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                    stall_next = 1'b0;
                end
                else
                begin
                    op_next = OP_PUSH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NONE;
            stall_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            stall_reg <= stall_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/core/evi_dp.sv]
module evi_dp
    import evi_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  in_word_t                  in_word,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_word_t                 out_word
);

    localparam int VB = VALUE_BITS;
    localparam int TB = TIME_BITS;
    localparam int FW = FRAC_BITS + 1;
    localparam int MW = ((VB + 1 > FW) ? VB + 1 : FW) + 1;
    localparam int PW = 2 * MW;
    localparam logic [FW-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] HALF_Q = {2'b01, {(FRAC_BITS - 1){1'b0}}};

    // Configuration registers
    ease_mode_t           mode_reg;
    logic [VB-1:0]        init_reg;
    logic [VB-1:0]        fin_reg;
    logic [TB-1:0]        dur_reg;

    // Item and animation state
    logic                 cmd_reg;
    logic [TB-1:0]        now_reg;
    logic                 finished_reg;
    logic [TB-1:0]        start_reg;
    logic [VB-1:0]        held_reg;

    // Work registers
    logic [TB-1:0]        rem_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic                 sat_reg;
    logic [FW-1:0]        x_reg;
    logic [FW-1:0]        e_reg;
    logic signed [PW-1:0] prod_reg;

    // Output stage
    out_word_t            out_word_reg;
    logic                 out_valid_reg;

    logic [TB-1:0]        end_time;
    logic [TB-1:0]        dt;
    logic                 dt_ge_dur;
    logic [FW-1:0]        f_val;
    logic                 f_lt_half;
    logic [FW-1:0]        x_next;
    logic [FW-1:0]        cube_v;
    logic [FW-1:0]        e_next;
    logic signed [VB:0]   diff_v;
    logic signed [MW-1:0] a_op;
    logic signed [MW-1:0] b_op;
    logic [TB:0]          rem_sh;
    logic                 rem_ge;
    logic [TB:0]          rem_sub;
    logic                 out_free;

    // Timing checks against the latched time
    assign end_time  = start_reg + dur_reg;
    assign dt        = now_reg - start_reg;
    assign dt_ge_dur = (dt >= dur_reg);

    assign out_free           = !out_valid_reg || !out_stall;
    assign status.is_start    = (cmd_reg == CMD_START);
    assign status.finished    = finished_reg;
    assign status.end_reached = (dur_reg == '0) || (now_reg >= end_time);
    assign status.out_free    = out_free;

    // Restoring divide step: one quotient bit a cycle
    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, dur_reg});
    assign rem_sub = rem_sh - {1'b0, dur_reg};

    // Elapsed fraction, saturated when dt is at or past the duration
    assign f_val     = sat_reg ? ONE_Q : {1'b0, q_reg};
    assign f_lt_half = (f_val < HALF_Q);
    assign cube_v    = prod_reg[FRAC_BITS +: FW];

    // Cube argument for the selected curve
    always_comb
    begin
        unique case (mode_reg)
            MODE_LINEAR:       x_next = f_val;
            MODE_CUBIC_IN:     x_next = f_val;
            MODE_CUBIC_OUT:    x_next = ONE_Q - f_val;
            MODE_CUBIC_IN_OUT: x_next = f_lt_half ? (f_val << 1) : ((ONE_Q - f_val) << 1);
            default:           x_next = f_val;
        endcase
    end

    // Eased fraction from the cube
    always_comb
    begin
        unique case (mode_reg)
            MODE_LINEAR:       e_next = f_val;
            MODE_CUBIC_IN:     e_next = cube_v;
            MODE_CUBIC_OUT:    e_next = ONE_Q - cube_v;
            MODE_CUBIC_IN_OUT: e_next = f_lt_half ? (cube_v >> 1) : (ONE_Q - (cube_v >> 1));
            default:           e_next = f_val;
        endcase
    end

    assign diff_v = $signed({fin_reg[VB-1], fin_reg}) - $signed({init_reg[VB-1], init_reg});

    // Shared multiplier operands
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        unique case (cmd.op)
            OP_SQ:
            begin
                a_op = $signed({{(MW - FW){1'b0}}, x_reg});
                b_op = $signed({{(MW - FW){1'b0}}, x_reg});
            end
            OP_CU:
            begin
                a_op = $signed({{(MW - FW){1'b0}}, cube_v});
                b_op = $signed({{(MW - FW){1'b0}}, x_reg});
            end
            OP_SCALE:
            begin
                a_op = $signed({{(MW - VB - 1){diff_v[VB]}}, diff_v});
                b_op = $signed({{(MW - FW){1'b0}}, e_reg});
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
            init_reg <= '0;
            fin_reg  <= '0;
            dur_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EASING_MODE:   mode_reg <= ease_mode_t'(cfg_data[1:0]);
                CFG_INITIAL_VALUE: init_reg <= cfg_data[VB-1:0];
                CFG_FINAL_VALUE:   fin_reg  <= cfg_data[VB-1:0];
                CFG_DURATION:      dur_reg  <= cfg_data[TB-1:0];
                default:           mode_reg <= mode_reg;
            endcase
        end
    end

    // Animation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg <= 1'b1;
            start_reg    <= '0;
            held_reg     <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_START:
                begin
                    finished_reg <= 1'b0;
                    start_reg    <= now_reg;
                    held_reg     <= init_reg;
                end
                OP_FINAL:
                begin
                    finished_reg <= 1'b1;
                    held_reg     <= fin_reg;
                end
                OP_SUM:
                begin
                    held_reg <= init_reg + prod_reg[FRAC_BITS +: VB];
                end
                default:
                begin
                    held_reg <= held_reg;
                end
            endcase
        end
    end

    // Input latch and arithmetic work registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_reg <= in_word.command;
            now_reg <= in_word.time_now;
        end
        unique case (cmd.op)
            OP_DIV_INIT:
            begin
                rem_reg <= dt;
                q_reg   <= '0;
                sat_reg <= dt_ge_dur;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_sub[TB-1:0] : rem_sh[TB-1:0];
                q_reg   <= {q_reg[FRAC_BITS-2:0], rem_ge};
            end
            OP_XSEL:
            begin
                x_reg <= x_next;
            end
            OP_SQ, OP_CU, OP_SCALE:
            begin
                prod_reg <= PW'(a_op) * PW'(b_op);
            end
            OP_EASE:
            begin
                e_reg <= e_next;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_PUSH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH && out_free)
        begin
            out_word_reg.current_value <= $signed(held_reg);
            out_word_reg.done_res      <= finished_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[rtl/core/eased_value_interpolator.sv]
// Path: a start or the step that finishes goes EVAL, APPLY, OUT; a step after
//   finish goes EVAL, OUT; an in-flight step goes EVAL, DINIT, DIV, XSEL, SQ, CU,
//   EASE, SCALE, SUM, OUT. Words go one at a time: the restoring divider (one
//   quotient bit a cycle) and the shared multiplier are on that path. Input is
//   taken again while a result still waits in the output register.
// Reset (async, active low): control and configuration registers zero, finished flag set, output empty.
module eased_value_interpolator
    import evi_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_word_t                  in_word,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_word_t                 out_word,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers take writes any time; software must write only while idle (not enforced)
    assign cfg_ready = 1'b1;

    evi_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    evi_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

[rtl/core/evi_chk.sv]
`include "eased_value_interpolator_defines.svh"

module evi_chk
    import evi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // One word in flight: an accept always closes the input for the next cycle
    `EVI_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

    // A new result shows up as the block finishes work and reopens the input
    `EVI_ASSERT_NOW(a_result_ends_work, $rose(out_valid), $past(in_stall) && !in_stall)

    // A stalled result holds
    `EVI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind eased_value_interpolator evi_chk u_evi_chk (.*);
